// ===== design/gtp_pkg.sv =====
// ----------------------------------------------------------------------------
// gtp_pkg: shared codes for the guillotine rectangle packer
// Action, status and cell operation codes used by the top level and the cells.
// ----------------------------------------------------------------------------
package gtp_pkg;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_GROW    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;
    localparam logic [1:0] ACT_NOP     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_DROP     = 2'd2;
    localparam logic [1:0] ST_SIZE     = 2'd3;

    localparam logic [1:0] OP_NONE     = 2'd0;
    localparam logic [1:0] OP_ERASE    = 2'd1;
    localparam logic [1:0] OP_INSERT   = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    typedef struct packed {
        logic [1:0] op;
    } t_cell_ctl;

endpackage

// ===== design/gtp_cell.sv =====
// ----------------------------------------------------------------------------
// gtp_cell: one entry of the sorted free-space chain
// Holds one free rectangle with its area and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module gtp_cell #(
    parameter int CB = 16,
    parameter int EW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gtp_pkg::t_cell_ctl    i_ctl,
    input  logic [1+6*CB-1:0]     i_new,
    input  logic [EW-1:0]         i_rw,
    input  logic [EW-1:0]         i_rh,
    input  logic [1+6*CB-1:0]     i_prev,
    input  logic                  i_prev_ge,
    input  logic [1+6*CB-1:0]     i_next,
    input  logic                  i_past,
    output logic [1+6*CB-1:0]     o_slot,
    output logic                  o_ge,
    output logic                  o_fit
);
    localparam int SW = 1 + 6 * CB;
    localparam int AW = 2 * CB;

    logic [SW-1:0] r_slot;
    logic [SW-1:0] n_slot;
    logic          v;
    logic [EW-1:0] w;
    logic [EW-1:0] h;

    assign v = r_slot[SW-1];
    assign w = EW'(r_slot[AW+2*CB-1 -: CB]);
    assign h = EW'(r_slot[AW+CB-1 -: CB]);

    assign o_ge  = !v || (r_slot[AW-1:0] >= i_new[AW-1:0]);
    assign o_fit = v && ((w >= i_rw && h >= i_rh) || (w >= i_rh && h >= i_rw));
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        case (i_ctl.op)
            gtp_pkg::OP_ERASE: begin
                if (i_past) n_slot = i_next;
            end
            gtp_pkg::OP_INSERT: begin
                // Sorted order makes the "not less" flags monotone along the chain.
                if (i_prev_ge) n_slot = i_prev;
                else if (o_ge) n_slot = i_new;
            end
            gtp_pkg::OP_CLEAR: n_slot = '0;
            default: n_slot = r_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_slot <= '0;
        else r_slot <= n_slot;
    end
endmodule

// ===== design/guillotine_rect_packer.sv =====
// ----------------------------------------------------------------------------
// guillotine_rect_packer: free-space manager for a texture atlas
// Sorted chain of free rectangles with guillotine splitting and atlas growth.
// ----------------------------------------------------------------------------
// An allocate item passes the search, the split, then a multiply and an
// insert per remainder (zero to two); a grow item a multiply and an insert
// per strip (zero to three); a restart a multiply and an insert for the new
// atlas; a no-operation goes straight to done. An item that finishes while
// the previous result is still waiting holds in the done state until that
// result is taken. The search over all cells is done in the search state;
// each insert uses the area multiplier and then the shift through the chain.
// After reset the block loads its first space before it takes an item.
module guillotine_rect_packer #(
    parameter int MAX_SPACES = 128,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_req_width,
    input  logic [15:0] i_req_height,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_placed,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [15:0] o_placed_width,
    output logic [15:0] o_placed_height,
    output logic        o_rotated,
    output logic [1:0]  o_status
);
    localparam int CB   = COORD_BITS;
    localparam int EW   = (CB > 16) ? CB : 16;
    localparam int AW   = 2 * CB;
    localparam int SW   = 1 + 6 * CB;
    localparam int CNTW = $clog2(MAX_SPACES + 1);
    localparam int LV   = $clog2(MAX_SPACES);
    localparam logic [CB:0] CMAX = {1'b0, {CB{1'b1}}};

    localparam logic [2:0] S_BOOT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_INS   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]      r_state;
    logic [15:0]     r_sw, r_sh;
    logic [CB-1:0]   r_aw, r_ah;
    logic [CNTW-1:0] r_cnt;
    logic [EW-1:0]   r_rw, r_rh;
    logic [4*CB-1:0] r_pq [3];
    logic [1:0]      r_pn, r_pi;
    logic [AW-1:0]   r_area;
    logic [SW-1:0]   r_sel;
    logic            r_found;
    logic            r_placed, r_rot;
    logic [15:0]     r_px, r_py, r_pw, r_ph;
    logic [1:0]      r_st;
    logic            r_ov;
    logic            r_o_placed, r_o_rot;
    logic [15:0]     r_o_px, r_o_py, r_o_pw, r_o_ph;
    logic [1:0]      r_o_st;
    logic            r_boot;

    gtp_pkg::t_cell_ctl ctl;
    logic [SW-1:0]   slot [MAX_SPACES];
    logic [MAX_SPACES-1:0] ge, fit;
    logic [MAX_SPACES-1:0] pre [LV+1];
    logic [SW-1:0]   new_slot;
    logic [SW-1:0]   sel_mux;
    logic            full;
    logic            acc;

    assign full = (r_cnt == CNTW'(MAX_SPACES));
    assign o_ready = (r_state == S_IDLE);
    assign acc = i_valid && o_ready;
    assign new_slot = {1'b1, r_pq[r_pi], r_area};

    always_comb begin
        ctl.op = gtp_pkg::OP_NONE;
        if (r_state == S_BOOT) ctl.op = gtp_pkg::OP_CLEAR;
        else if (acc && i_action == gtp_pkg::ACT_RESTART) ctl.op = gtp_pkg::OP_CLEAR;
        else if (r_state == S_SRCH && pre[LV][MAX_SPACES-1]) ctl.op = gtp_pkg::OP_ERASE;
        else if (r_state == S_INS && !full) ctl.op = gtp_pkg::OP_INSERT;
    end

    // Inclusive prefix OR of the fit flags marks the chosen cell and all after it.
    always_comb begin
        pre[0] = fit;
        for (int l = 0; l < LV; l++) begin
            pre[l+1] = pre[l];
            for (int i = 0; i < MAX_SPACES; i++) begin
                if (i >= (1 << l)) pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
            end
        end
    end

    always_comb begin
        sel_mux = '0;
        for (int i = 0; i < MAX_SPACES; i++) begin
            if (fit[i] && (i == 0 || !pre[LV][(i == 0) ? 0 : i-1])) sel_mux = sel_mux | slot[i];
        end
    end

    for (genvar g = 0; g < MAX_SPACES; g++) begin : g_cell
        gtp_cell #(.CB(CB), .EW(EW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_new     (new_slot),
            .i_rw      (r_rw),
            .i_rh      (r_rh),
            .i_prev    ((g == 0) ? '0 : slot[(g == 0) ? 0 : g-1]),
            .i_prev_ge ((g == 0) ? 1'b0 : ge[(g == 0) ? 0 : g-1]),
            .i_next    ((g == MAX_SPACES-1) ? '0 : slot[(g == MAX_SPACES-1) ? g : g+1]),
            .i_past    (pre[LV][g]),
            .o_slot    (slot[g]),
            .o_ge      (ge[g]),
            .o_fit     (fit[g])
        );
    end

    // Split of the chosen space.
    logic [CB-1:0] sx, sy, sw_, sh_, iw, ih, fw, fh;
    logic          rot;
    assign sx  = r_sel[AW+4*CB-1 -: CB];
    assign sy  = r_sel[AW+3*CB-1 -: CB];
    assign sw_ = r_sel[AW+2*CB-1 -: CB];
    assign sh_ = r_sel[AW+CB-1 -: CB];
    assign rot = !(EW'(sw_) >= r_rw && EW'(sh_) >= r_rh);
    assign iw  = rot ? CB'(r_rh) : CB'(r_rw);
    assign ih  = rot ? CB'(r_rw) : CB'(r_rh);
    assign fw  = sw_ - iw;
    assign fh  = sh_ - ih;

    // Grow sums.
    logic [EW:0] gw, gh;
    assign gw = (EW+1)'(r_aw) + (EW+1)'(i_req_width);
    assign gh = (EW+1)'(r_ah) + (EW+1)'(i_req_height);
    logic [CB-1:0] dw, dh;
    assign dw = CB'(i_req_width);
    assign dh = CB'(i_req_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
            r_sw    <= 16'd1024;
            r_sh    <= 16'd1024;
            r_cnt   <= '0;
            r_pn    <= '0;
            r_pi    <= '0;
            r_ov    <= 1'b0;
            r_aw    <= CB'(1024);
            r_ah    <= CB'(1024);
        end else begin
            if (i_cfg_we && i_cfg_index == 8'd0) r_sw <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == 8'd1) r_sh <= i_cfg_data;
            if (r_state == S_DONE && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_BOOT: begin
                    r_cnt   <= '0;
                    r_pq[0] <= {CB'(0), CB'(0), CB'(r_sw), CB'(r_sh)};
                    r_pn    <= 2'd1;
                    r_pi    <= '0;
                    r_aw    <= CB'(r_sw);
                    r_ah    <= CB'(r_sh);
                    r_st    <= gtp_pkg::ST_OK;
                    r_placed <= 1'b0; r_rot <= 1'b0;
                    r_px <= '0; r_py <= '0; r_pw <= '0; r_ph <= '0;
                    r_state <= S_MUL;
                end
                S_IDLE: begin
                    if (acc) begin
                        r_rw <= EW'(i_req_width);
                        r_rh <= EW'(i_req_height);
                        r_placed <= 1'b0; r_rot <= 1'b0;
                        r_px <= '0; r_py <= '0; r_pw <= '0; r_ph <= '0;
                        r_pi <= '0;
                        case (i_action)
                            gtp_pkg::ACT_ALLOC: begin
                                r_st    <= gtp_pkg::ST_OK;
                                r_pn    <= '0;
                                r_state <= S_SRCH;
                            end
                            gtp_pkg::ACT_GROW: begin
                                if (gw > (EW+1)'(CMAX) || gh > (EW+1)'(CMAX)) begin
                                    r_st    <= gtp_pkg::ST_SIZE;
                                    r_pn    <= '0;
                                    r_state <= S_DONE;
                                end else begin
                                    r_st <= gtp_pkg::ST_OK;
                                    r_aw <= CB'(gw);
                                    r_ah <= CB'(gh);
                                    if (dw != '0 && dh != '0) begin
                                        r_pq[0] <= {r_aw, CB'(0), dw, r_ah};
                                        r_pq[1] <= {CB'(0), r_ah, r_aw, dh};
                                        r_pq[2] <= {r_aw, r_ah, dw, dh};
                                        r_pn <= 2'd3;
                                        r_state <= S_MUL;
                                    end else if (dw != '0) begin
                                        r_pq[0] <= {r_aw, CB'(0), dw, r_ah};
                                        r_pn <= 2'd1;
                                        r_state <= S_MUL;
                                    end else if (dh != '0) begin
                                        r_pq[0] <= {CB'(0), r_ah, r_aw, dh};
                                        r_pn <= 2'd1;
                                        r_state <= S_MUL;
                                    end else begin
                                        r_pn <= '0;
                                        r_state <= S_DONE;
                                    end
                                end
                            end
                            gtp_pkg::ACT_RESTART: begin
                                r_st    <= gtp_pkg::ST_OK;
                                r_cnt   <= '0;
                                r_pq[0] <= {CB'(0), CB'(0), CB'(r_sw), CB'(r_sh)};
                                r_pn    <= 2'd1;
                                r_aw    <= CB'(r_sw);
                                r_ah    <= CB'(r_sh);
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_st    <= gtp_pkg::ST_OK;
                                r_pn    <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    r_sel   <= sel_mux;
                    r_found <= pre[LV][MAX_SPACES-1];
                    if (pre[LV][MAX_SPACES-1]) r_cnt <= r_cnt - 1'b1;
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    if (!r_found) begin
                        r_st    <= gtp_pkg::ST_NOFIT;
                        r_state <= S_DONE;
                    end else begin
                        r_placed <= 1'b1;
                        r_rot    <= rot;
                        r_px     <= 16'(sx);
                        r_py     <= 16'(sy);
                        r_pw     <= 16'(iw);
                        r_ph     <= 16'(ih);
                        if (fw == '0 && fh == '0) begin
                            r_pn <= 2'd0;
                            r_state <= S_DONE;
                        end else if (fh == '0) begin
                            r_pq[0] <= {sx + iw, sy, fw, sh_};
                            r_pn <= 2'd1;
                            r_state <= S_MUL;
                        end else if (fw == '0) begin
                            r_pq[0] <= {sx, sy + ih, sw_, fh};
                            r_pn <= 2'd1;
                            r_state <= S_MUL;
                        end else if (fw > fh) begin
                            r_pq[0] <= {sx + iw, sy, fw, sh_};
                            r_pq[1] <= {sx, sy + ih, iw, fh};
                            r_pn <= 2'd2;
                            r_state <= S_MUL;
                        end else begin
                            r_pq[0] <= {sx, sy + ih, sw_, fh};
                            r_pq[1] <= {sx + iw, sy, fw, ih};
                            r_pn <= 2'd2;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_area  <= AW'(r_pq[r_pi][2*CB-1 -: CB]) * AW'(r_pq[r_pi][CB-1:0]);
                    r_state <= S_INS;
                end
                S_INS: begin
                    if (full) r_st <= gtp_pkg::ST_DROP;
                    else r_cnt <= r_cnt + 1'b1;
                    r_pi <= r_pi + 1'b1;
                    // The load that follows reset gives no result item.
                    if (r_pi + 2'd1 == r_pn) r_state <= r_boot ? S_IDLE : S_DONE;
                    else r_state <= S_MUL;
                end
                S_DONE: begin
                    if (!r_ov || i_ready) begin
                        r_o_placed <= r_placed;
                        r_o_rot    <= r_rot;
                        r_o_px     <= r_px;
                        r_o_py     <= r_py;
                        r_o_pw     <= r_pw;
                        r_o_ph     <= r_ph;
                        r_o_st     <= r_st;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Marks the load that follows reset, which gives no result item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_boot <= 1'b1;
        else if (r_state == S_INS) r_boot <= 1'b0;
    end

    assign o_valid         = r_ov;
    assign o_placed        = r_o_placed;
    assign o_pos_x         = r_o_px;
    assign o_pos_y         = r_o_py;
    assign o_placed_width  = r_o_pw;
    assign o_placed_height = r_o_ph;
    assign o_rotated       = r_o_rot;
    assign o_status        = r_o_st;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(MAX_SPACES)) else $error("space count beyond capacity");
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_cnt != '0) == slot[0][SW-1]))
        else $error("head cell valid disagrees with count");
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS && !full) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("insert did not grow the list");
endmodule

// ===== verif/guillotine_rect_packer_tb.sv =====
// ----------------------------------------------------------------------------
// guillotine_rect_packer_tb: self-checking bench for the guillotine packer
// Drives allocate, grow, restart and no-operation items with random gaps on
// both channels, predicts each result with a behavioral free-space list and
// compares every result field by field in order.
// ----------------------------------------------------------------------------
module guillotine_rect_packer_tb;

    localparam int NUM_SPACES = 128;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } t_space;

    typedef struct packed {
        logic        placed;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pw;
        logic [15:0] ph;
        logic        rotated;
        logic [1:0]  status;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = gtp_pkg::ACT_NOP;
    logic [15:0] i_req_width = '0;
    logic [15:0] i_req_height = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_placed;
    logic [15:0] o_pos_x, o_pos_y, o_placed_width, o_placed_height;
    logic        o_rotated;
    logic [1:0]  o_status;

    guillotine_rect_packer u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state.
    t_space      free_list[NUM_SPACES];
    int          free_count;
    logic [15:0] atlas_w, atlas_h, cfg_w, cfg_h;
    t_result     pending_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          stall_free = 1'b0;
    int          ready_wait = 0;

    function automatic logic [31:0] area(logic [15:0] w, logic [15:0] h);
        return 32'(w) * 32'(h);
    endfunction

    function automatic int first_fit_index(logic [31:0] a);
        int i;
        i = 0;
        while (i < free_count && area(free_list[i].w, free_list[i].h) < a) i++;
        return i;
    endfunction

    function automatic bit insert_space(logic [15:0] x, logic [15:0] y,
                                        logic [15:0] w, logic [15:0] h);
        int pos;
        if (free_count >= NUM_SPACES) return 1'b0;
        pos = first_fit_index(area(w, h));
        for (int k = free_count; k > pos; k--) free_list[k] = free_list[k-1];
        free_list[pos] = '{x, y, w, h};
        free_count++;
        return 1'b1;
    endfunction

    function automatic bit split_space(int pos, logic [15:0] iw, logic [15:0] ih);
        t_space s;
        logic [15:0] fw, fh;
        bit ok;
        s = free_list[pos];
        fw = s.w - iw;
        fh = s.h - ih;
        ok = 1'b1;
        for (int k = pos; k < free_count - 1; k++) free_list[k] = free_list[k+1];
        free_count--;
        if (fw == 0 && fh == 0) return 1'b1;
        if (fh == 0) return insert_space(s.x + iw, s.y, fw, s.h);
        if (fw == 0) return insert_space(s.x, s.y + ih, s.w, fh);
        if (fw > fh) begin
            ok = insert_space(s.x + iw, s.y, fw, s.h) && ok;
            ok = insert_space(s.x, s.y + ih, iw, fh) && ok;
        end else begin
            ok = insert_space(s.x, s.y + ih, s.w, fh) && ok;
            ok = insert_space(s.x + iw, s.y, fw, ih) && ok;
        end
        return ok;
    endfunction

    function automatic void restart_atlas();
        free_count = 1;
        free_list[0] = '{16'd0, 16'd0, cfg_w, cfg_h};
        atlas_w = cfg_w;
        atlas_h = cfg_h;
    endfunction

    function automatic t_result predict_packing(logic [1:0] act, logic [15:0] rw,
                                                logic [15:0] rh);
        t_result r;
        logic [15:0] iw, ih;
        logic [16:0] nw, nh;
        bit ok, fits;
        r = '0;
        case (act)
            gtp_pkg::ACT_ALLOC: begin
                r.status = gtp_pkg::ST_NOFIT;
                for (int i = first_fit_index(area(rw, rh)); i < free_count; i++) begin
                    fits = 1'b1;
                    if (free_list[i].w >= rw && free_list[i].h >= rh) begin
                        iw = rw; ih = rh; r.rotated = 1'b0;
                    end else if (free_list[i].w >= rh && free_list[i].h >= rw) begin
                        iw = rh; ih = rw; r.rotated = 1'b1;
                    end else begin
                        fits = 1'b0;
                    end
                    if (fits) begin
                        r.placed = 1'b1;
                        r.pos_x = free_list[i].x;
                        r.pos_y = free_list[i].y;
                        r.pw = iw;
                        r.ph = ih;
                        r.status = split_space(i, iw, ih) ? gtp_pkg::ST_OK : gtp_pkg::ST_DROP;
                        break;
                    end
                end
            end
            gtp_pkg::ACT_GROW: begin
                nw = 17'(atlas_w) + 17'(rw);
                nh = 17'(atlas_h) + 17'(rh);
                if (nw[16] || nh[16]) begin
                    r.status = gtp_pkg::ST_SIZE;
                end else begin
                    ok = 1'b1;
                    if (rw > 0) ok = insert_space(atlas_w, 16'd0, rw, atlas_h) && ok;
                    if (rh > 0) ok = insert_space(16'd0, atlas_h, atlas_w, rh) && ok;
                    if (rw > 0 && rh > 0) ok = insert_space(atlas_w, atlas_h, rw, rh) && ok;
                    atlas_w = nw[15:0];
                    atlas_h = nh[15:0];
                    r.status = ok ? gtp_pkg::ST_OK : gtp_pkg::ST_DROP;
                end
            end
            gtp_pkg::ACT_RESTART: restart_atlas();
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("ERROR %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_item(logic [1:0] act, logic [15:0] rw, logic [15:0] rh);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 15);
        repeat (gap) @(negedge i_clk);
        i_valid = 1'b1;
        i_action = act;
        i_req_width = rw;
        i_req_height = rh;
        pending_results.push_back(predict_packing(act, rw, rh));
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_start_size(logic [15:0] w, logic [15:0] h);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_index = 8'd0;
        i_cfg_data = w;
        @(negedge i_clk);
        i_cfg_index = 8'd1;
        i_cfg_data = h;
        @(negedge i_clk);
        // An index past the two registers must leave them alone.
        i_cfg_index = 8'd2 + 8'($urandom_range(0, 253));
        i_cfg_data = 16'($urandom);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_w = w;
        cfg_h = h;
    endtask

    // Result checker; each taken result draws the wait for the next one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            ready_wait = stall_free ? 0 : $urandom_range(0, 15);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 16'd1, 16'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_placed !== want.placed)
                    report_mismatch("placed", 16'(o_placed), 16'(want.placed));
                if (o_pos_x !== want.pos_x) report_mismatch("pos_x", o_pos_x, want.pos_x);
                if (o_pos_y !== want.pos_y) report_mismatch("pos_y", o_pos_y, want.pos_y);
                if (o_placed_width !== want.pw)
                    report_mismatch("placed_width", o_placed_width, want.pw);
                if (o_placed_height !== want.ph)
                    report_mismatch("placed_height", o_placed_height, want.ph);
                if (o_rotated !== want.rotated)
                    report_mismatch("rotated", 16'(o_rotated), 16'(want.rotated));
                if (o_status !== want.status)
                    report_mismatch("status", 16'(o_status), 16'(want.status));
            end
        end
    end

    // Ready is held low while a result is waiting, until the drawn wait has run down.
    always @(negedge i_clk) begin
        if (o_valid && ready_wait > 0) begin
            i_ready <= 1'b0;
            ready_wait--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(gtp_pkg::ACT_ALLOC, 16'd0, 16'd0);
        send_item(gtp_pkg::ACT_ALLOC, 16'd100, 16'd40);
        send_item(gtp_pkg::ACT_ALLOC, 16'd40, 16'd1000);
        send_item(gtp_pkg::ACT_ALLOC, 16'd924, 16'd100);
        send_item(gtp_pkg::ACT_ALLOC, 16'd2000, 16'd1);
        send_item(gtp_pkg::ACT_ALLOC, 16'hFFFF, 16'hFFFF);
        send_item(gtp_pkg::ACT_ALLOC, 16'd1, 16'd1);
        send_item(gtp_pkg::ACT_NOP, 16'hFFFF, 16'hFFFF);
        send_item(gtp_pkg::ACT_GROW, 16'd0, 16'd0);
        send_item(gtp_pkg::ACT_GROW, 16'd50, 16'd0);
        send_item(gtp_pkg::ACT_GROW, 16'd0, 16'd50);
        send_item(gtp_pkg::ACT_GROW, 16'd30, 16'd30);
        send_item(gtp_pkg::ACT_GROW, 16'hFFFF, 16'd0);
        send_item(gtp_pkg::ACT_GROW, 16'd0, 16'hFFFF);
        send_item(gtp_pkg::ACT_RESTART, 16'd0, 16'd0);
        send_item(gtp_pkg::ACT_ALLOC, 16'd1024, 16'd1024);
        send_item(gtp_pkg::ACT_ALLOC, 16'd1, 16'd1);
        send_item(gtp_pkg::ACT_RESTART, 16'h5555, 16'hAAAA);
        send_item(gtp_pkg::ACT_ALLOC, 16'd512, 16'd512);
        send_item(gtp_pkg::ACT_ALLOC, 16'd512, 16'd512);
    endtask

    task automatic test_extreme_sizes();
        write_start_size(16'hFFFF, 16'hFFFF);
        send_item(gtp_pkg::ACT_RESTART, 16'd0, 16'd0);
        send_item(gtp_pkg::ACT_ALLOC, 16'hFFFF, 16'd1);
        send_item(gtp_pkg::ACT_GROW, 16'd1, 16'd0);
        write_start_size(16'd1, 16'd1);
        send_item(gtp_pkg::ACT_RESTART, 16'd0, 16'd0);
        send_item(gtp_pkg::ACT_ALLOC, 16'd1, 16'd1);
        send_item(gtp_pkg::ACT_ALLOC, 16'd0, 16'd0);
        send_item(gtp_pkg::ACT_GROW, 16'hFFFE, 16'hFFFE);
    endtask

    // Many small grows and allocations fill the free list until spaces drop.
    task automatic test_list_overflow();
        write_start_size(16'd4096, 16'd4096);
        send_item(gtp_pkg::ACT_RESTART, 16'd0, 16'd0);
        for (int i = 0; i < 90; i++)
            send_item(gtp_pkg::ACT_ALLOC, 16'($urandom_range(1, 40)),
                      16'($urandom_range(1, 40)));
        for (int i = 0; i < 20; i++) send_item(gtp_pkg::ACT_GROW, 16'd3, 16'd3);
    endtask

    task automatic test_random(int count);
        int kind;
        logic [15:0] rw, rh;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                write_start_size(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)));
                send_item(gtp_pkg::ACT_RESTART, 16'($urandom), 16'($urandom));
            end
            if (i == count / 2) begin
                // Burst with no gaps on either side, after a full drain.
                wait_drained();
                stall_free = 1'b1;
            end
            if (i == count / 2 + 60) stall_free = 1'b0;
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                rw = (kind < 5) ? 16'($urandom) : 16'($urandom_range(0, 300));
                rh = (kind < 5) ? 16'($urandom) : 16'($urandom_range(0, 300));
                send_item(gtp_pkg::ACT_ALLOC, rw, rh);
            end else if (kind < 90) begin
                rw = (kind < 83) ? 16'($urandom) : 16'($urandom_range(0, 200));
                rh = (kind < 83) ? 16'($urandom) : 16'($urandom_range(0, 200));
                send_item(gtp_pkg::ACT_GROW, rw, rh);
            end else if (kind < 94) begin
                send_item(gtp_pkg::ACT_RESTART, 16'($urandom), 16'($urandom));
            end else begin
                send_item(gtp_pkg::ACT_NOP, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        cfg_w = 16'd1024;
        cfg_h = 16'd1024;
        for (int i = 0; i < NUM_SPACES; i++) free_list[i] = '{16'd0, 16'd0, 16'd0, 16'd0};
        restart_atlas();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_extreme_sizes();
        test_list_overflow();
        test_random(1100);
        wait_drained();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/gtp_pkg.sv
design/gtp_cell.sv
design/guillotine_rect_packer.sv
verif/guillotine_rect_packer_tb.sv
